// ----- hdl/tgpr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgpr_pkg
// Shared types, constants, glyph table and microcode for the glyph renderer.
// ----------------------------------------------------------------------------
package tgpr_pkg;

    localparam int COLUMNS_DEF  = 128;
    localparam int PAGES_DEF    = 8;
    localparam int STORE_DEPTH  = 1024;
    localparam int STORE_AW     = 10;
    localparam int CELL_WIDTH   = 6;
    localparam int GLYPH_FIRST  = 32;
    localparam int GLYPH_LAST   = 127;
    localparam int NEWLINE_CODE = 10;
    localparam int GLYPH_COUNT  = 96;
    localparam int IN_TDATA_W   = 40;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 24;

    typedef enum logic [1:0] {
        CMD_SET_CURSOR = 2'd0,
        CMD_PUT_CHAR   = 2'd1,
        CMD_CLEAR      = 2'd2,
        CMD_READ       = 2'd3
    } t_cmd;

    // Program addresses of the sequencer.
    typedef enum logic [2:0] {
        ST_FETCH  = 3'd0,
        ST_SETCUR = 3'd1,
        ST_PUTCHK = 3'd2,
        ST_DRAW   = 3'd3,
        ST_CLEAR  = 3'd4,
        ST_RDREQ  = 3'd5,
        ST_RDCAP  = 3'd6,
        ST_EMIT   = 3'd7
    } t_step;

    typedef enum logic [2:0] {
        UOP_FETCH  = 3'd0,
        UOP_SETCUR = 3'd1,
        UOP_PUTCHK = 3'd2,
        UOP_DRAW   = 3'd3,
        UOP_CLEAR  = 3'd4,
        UOP_RDREQ  = 3'd5,
        UOP_RDCAP  = 3'd6,
        UOP_EMIT   = 3'd7
    } t_uop;

    // One control word: the datapath operation, the target taken when the
    // operation's condition holds, and the step that follows otherwise.
    typedef struct packed {
        t_uop  op;
        t_step jmp;
        t_step seq;
    } t_cw;

    function automatic t_cw ucode(input t_step s);
        t_cw cw;
        case (s)
            ST_FETCH:  cw = '{op: UOP_FETCH,  jmp: ST_FETCH,  seq: ST_FETCH};
            ST_SETCUR: cw = '{op: UOP_SETCUR, jmp: ST_EMIT,   seq: ST_EMIT};
            ST_PUTCHK: cw = '{op: UOP_PUTCHK, jmp: ST_EMIT,   seq: ST_DRAW};
            ST_DRAW:   cw = '{op: UOP_DRAW,   jmp: ST_DRAW,   seq: ST_EMIT};
            ST_CLEAR:  cw = '{op: UOP_CLEAR,  jmp: ST_CLEAR,  seq: ST_EMIT};
            ST_RDREQ:  cw = '{op: UOP_RDREQ,  jmp: ST_RDCAP,  seq: ST_RDCAP};
            ST_RDCAP:  cw = '{op: UOP_RDCAP,  jmp: ST_EMIT,   seq: ST_EMIT};
            ST_EMIT:   cw = '{op: UOP_EMIT,   jmp: ST_EMIT,   seq: ST_FETCH};
            default:   cw = '{op: UOP_FETCH,  jmp: ST_FETCH,  seq: ST_FETCH};
        endcase
        return cw;
    endfunction

    function automatic t_step dispatch(input t_cmd c);
        t_step s;
        case (c)
            CMD_SET_CURSOR: s = ST_SETCUR;
            CMD_PUT_CHAR:   s = ST_PUTCHK;
            CMD_CLEAR:      s = ST_CLEAR;
            CMD_READ:       s = ST_RDREQ;
            default:        s = ST_FETCH;
        endcase
        return s;
    endfunction

    // Five glyph columns per character, leftmost column in the top byte.
    localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'h0000000000
    };

    // Column k of glyph g; column five is the blank spacer.
    function automatic logic [7:0] glyph_column(input logic [6:0] g, input logic [2:0] k);
        logic [39:0] e;
        logic [7:0]  c;
        e = GLYPH_ROM[g];
        case (k)
            3'd0:    c = e[39:32];
            3'd1:    c = e[31:24];
            3'd2:    c = e[23:16];
            3'd3:    c = e[15:8];
            3'd4:    c = e[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/text_glyph_page_renderer.sv -----
// ----------------------------------------------------------------------------
// text_glyph_page_renderer
// Draws 5x7 characters into a page-organized monochrome frame store.
// ----------------------------------------------------------------------------
// One item is handled at a time by a small microcoded sequencer; every item
// gives one result, held in an output register so the next item can be taken
// while the result waits. A drawn character takes six store writes through the
// single write port of the store; a clear writes one store byte per cycle.
// After reset the block runs a clearing pass over the store before it accepts
// its first item.
// ----------------------------------------------------------------------------
module text_glyph_page_renderer #(
    parameter int COLUMNS = tgpr_pkg::COLUMNS_DEF,
    parameter int PAGES   = tgpr_pkg::PAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // char_code[7:0], target_column[15:8], target_page[23:16],
    // read_address[33:24], zero fill[39:34]
    input  logic [tgpr_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // command[1:0]
    input  logic [tgpr_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // read_data[7:0], column_now[15:8], page_now[18:16], char_dropped[19],
    // zero fill[23:20]
    output logic [tgpr_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam logic [8:0]  ColLimit  = 9'(COLUMNS - tgpr_pkg::CELL_WIDTH);
    localparam logic [8:0]  ColCount  = 9'(COLUMNS);
    localparam logic [8:0]  PageCount = 9'(PAGES);
    localparam logic [2:0]  PageLast  = 3'(PAGES - 1);
    localparam logic [2:0]  LastCol   = 3'(tgpr_pkg::CELL_WIDTH - 1);
    localparam logic [11:0] StoreEnd  = 12'(tgpr_pkg::STORE_DEPTH);

    tgpr_pkg::t_step r_pc;
    tgpr_pkg::t_step n_pc;
    tgpr_pkg::t_cmd  r_cmd;
    tgpr_pkg::t_cw   w_cw;

    logic                             r_boot;
    logic [7:0]                       r_code;
    logic [7:0]                       r_tcol;
    logic [7:0]                       r_tpage;
    logic [tgpr_pkg::STORE_AW-1:0]    r_raddr;
    logic [7:0]                       r_col;
    logic [2:0]                       r_page;
    logic [tgpr_pkg::STORE_AW-1:0]    r_addr;
    logic [2:0]                       r_k;
    logic [6:0]                       r_glyph;
    logic [7:0]                       r_rdata;
    logic                             r_drop;
    logic                             r_ovalid;
    logic [tgpr_pkg::OUT_TDATA_W-1:0] r_odata;

    logic        w_s_acc;
    logic        w_slot_free;
    logic        w_is_nl;
    logic        w_print;
    logic [6:0]  w_gidx;
    logic [11:0] w_base;
    logic        w_nofit;
    logic        w_cond;
    logic        w_we;
    logic [7:0]  w_wdata;
    logic [7:0]  w_ram_rdata;
    logic        w_addr_last;

    assign w_cw        = tgpr_pkg::ucode(r_pc);
    assign w_s_acc     = i_s_axis_tvalid && (w_cw.op == tgpr_pkg::UOP_FETCH);
    assign w_slot_free = !r_ovalid || i_m_axis_tready;
    assign w_addr_last = (r_addr == {tgpr_pkg::STORE_AW{1'b1}});

    assign w_is_nl = (r_code == 8'(tgpr_pkg::NEWLINE_CODE));
    assign w_print = (r_code >= 8'(tgpr_pkg::GLYPH_FIRST))
                  && (r_code <= 8'(tgpr_pkg::GLYPH_LAST));
    assign w_gidx  = w_print ? 7'(r_code - 8'(tgpr_pkg::GLYPH_FIRST)) : 7'd0;
    assign w_base  = 12'(r_page) * 12'(COLUMNS) + 12'(r_col);
    assign w_nofit = ({1'b0, r_col} > ColLimit)
                  || (w_base + 12'(tgpr_pkg::CELL_WIDTH) > StoreEnd);

    always_comb begin
        case (w_cw.op)
            tgpr_pkg::UOP_FETCH:  w_cond = !w_s_acc;
            tgpr_pkg::UOP_PUTCHK: w_cond = w_is_nl || w_nofit;
            tgpr_pkg::UOP_DRAW:   w_cond = (r_k != LastCol);
            tgpr_pkg::UOP_CLEAR:  w_cond = !w_addr_last;
            tgpr_pkg::UOP_EMIT:   w_cond = !w_slot_free;
            default:              w_cond = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = w_cond ? w_cw.jmp : w_cw.seq;
        if (w_s_acc) begin
            n_pc = tgpr_pkg::dispatch(tgpr_pkg::t_cmd'(i_s_axis_tuser));
        end
        // The clearing pass after reset produces no result.
        if (w_cw.op == tgpr_pkg::UOP_CLEAR && w_addr_last && r_boot) begin
            n_pc = tgpr_pkg::ST_FETCH;
        end
    end

    assign w_we    = (w_cw.op == tgpr_pkg::UOP_DRAW) || (w_cw.op == tgpr_pkg::UOP_CLEAR);
    assign w_wdata = (w_cw.op == tgpr_pkg::UOP_DRAW) ?
                     tgpr_pkg::glyph_column(r_glyph, r_k) : 8'h00;

    tgpr_ram #(
        .WIDTH (8),
        .DEPTH (tgpr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_raddr (r_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= tgpr_pkg::ST_CLEAR;
            r_boot   <= 1'b1;
            r_addr   <= '0;
            r_col    <= '0;
            r_page   <= '0;
            r_k      <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_cw.op == tgpr_pkg::UOP_EMIT && w_slot_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (w_cw.op)
                tgpr_pkg::UOP_FETCH: begin
                    if (w_s_acc) begin
                        r_cmd   <= tgpr_pkg::t_cmd'(i_s_axis_tuser);
                        r_code  <= i_s_axis_tdata[7:0];
                        r_tcol  <= i_s_axis_tdata[15:8];
                        r_tpage <= i_s_axis_tdata[23:16];
                        r_raddr <= i_s_axis_tdata[33:24];
                        r_rdata <= 8'h00;
                        r_drop  <= 1'b0;
                        r_addr  <= '0;
                    end
                end
                tgpr_pkg::UOP_SETCUR: begin
                    if ({1'b0, r_tcol} < ColCount) begin
                        r_col <= r_tcol;
                    end
                    if ({1'b0, r_tpage} < PageCount) begin
                        r_page <= r_tpage[2:0];
                    end
                end
                tgpr_pkg::UOP_PUTCHK: begin
                    if (w_is_nl) begin
                        r_col  <= '0;
                        r_page <= (r_page == PageLast) ? r_page : r_page + 3'd1;
                    end else if (w_nofit) begin
                        r_drop <= 1'b1;
                    end else begin
                        r_addr  <= w_base[tgpr_pkg::STORE_AW-1:0];
                        r_k     <= '0;
                        r_glyph <= w_gidx;
                    end
                end
                tgpr_pkg::UOP_DRAW: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_k == LastCol) begin
                        r_col <= r_col + 8'(tgpr_pkg::CELL_WIDTH);
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                tgpr_pkg::UOP_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (w_addr_last) begin
                        r_col  <= '0;
                        r_page <= '0;
                        r_boot <= 1'b0;
                    end
                end
                tgpr_pkg::UOP_RDREQ: begin
                    // The store registers the byte at the read address during this step.
                end
                tgpr_pkg::UOP_RDCAP: begin
                    r_rdata <= w_ram_rdata;
                end
                tgpr_pkg::UOP_EMIT: begin
                    if (w_slot_free) begin
                        r_odata <= {4'h0, r_drop, r_page, r_col, r_rdata};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = (w_cw.op == tgpr_pkg::UOP_FETCH);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // An accepted item always leaves the fetch step.
    a_accept_leaves_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_pc != tgpr_pkg::ST_FETCH))
        else $error("sequencer stayed in fetch after accepting an item");

    // The glyph column counter never runs past the blank column.
    a_col_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == tgpr_pkg::ST_DRAW) |-> (r_k <= LastCol))
        else $error("glyph column counter out of range");

    // A drop can only come from a put-character item.
    a_drop_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_cmd == tgpr_pkg::CMD_PUT_CHAR))
        else $error("drop flag set for a command other than put character");

    // The cursor column stays at most COLUMNS and the page stays inside the page grid.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} <= ColCount) && ({6'd0, r_page} < PageCount))
        else $error("cursor outside the page grid");

endmodule

// ----- hdl/tgpr_ram.sv -----
// ----------------------------------------------------------------------------
// tgpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tgpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/frame_mirror_pkg.sv -----
// ----------------------------------------------------------------------------
// frame_mirror_pkg
// Mirror of the glyph renderer's frame store and cursor. Each accepted
// command is applied to the mirror and the result it must give is queued.
// Returned results are checked field by field against that queue.
// ----------------------------------------------------------------------------
package frame_mirror_pkg;
    import tgpr_pkg::*;

    localparam int MIRROR_COLS  = 128;
    localparam int MIRROR_PAGES = 8;

    // Result fields as they sit in the low 20 bits of the output tdata.
    typedef struct packed {
        logic       dropped;
        logic [2:0] page;
        logic [7:0] column;
        logic [7:0] rdata;
    } t_render_result;

    // Five columns per glyph, leftmost column in the top byte.
    localparam logic [39:0] FONT_5X7 [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'h0000000000
    };

    class frame_mirror;
        logic [7:0]     frame [STORE_DEPTH];
        int unsigned    column;
        int unsigned    page;
        t_render_result due_results [$];
        int             errors;
        int             results_seen;

        function new();
            wipe();
            errors       = 0;
            results_seen = 0;
        endfunction

        function void wipe();
            foreach (frame[i]) frame[i] = 8'h00;
            column = 0;
            page   = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Draws at the cursor or takes a newline; returns 1 if it did not fit.
        function bit place_glyph(input logic [7:0] code);
            int unsigned base;
            int unsigned g;
            logic [39:0] cols;
            if (code == NEWLINE_CODE) begin
                page   = (page + 1 < MIRROR_PAGES) ? page + 1 : MIRROR_PAGES - 1;
                column = 0;
                return 1'b0;
            end
            if (code < GLYPH_FIRST || code > GLYPH_LAST) code = GLYPH_FIRST;
            if (column > MIRROR_COLS - CELL_WIDTH) return 1'b1;
            base = page * MIRROR_COLS + column;
            if (base + CELL_WIDTH > STORE_DEPTH) return 1'b1;
            g    = code - GLYPH_FIRST;
            cols = FONT_5X7[g];
            for (int k = 0; k < 5; k++) frame[base + k] = cols[39 - 8 * k -: 8];
            frame[base + 5] = 8'h00;
            column = (column + CELL_WIDTH) & 8'hFF;
            return 1'b0;
        endfunction

        function void note_command(input t_cmd cmd, input logic [39:0] data);
            t_render_result r;
            logic [7:0]     tcol;
            logic [7:0]     tpage;
            r     = '0;
            tcol  = data[15:8];
            tpage = data[23:16];
            case (cmd)
                CMD_SET_CURSOR: begin
                    if (tcol < MIRROR_COLS) column = tcol;
                    if (tpage < MIRROR_PAGES) page = tpage;
                end
                CMD_PUT_CHAR: r.dropped = place_glyph(data[7:0]);
                CMD_CLEAR:    wipe();
                default:      r.rdata = frame[data[33:24]];
            endcase
            r.column = 8'(column);
            r.page   = 3'(page);
            due_results.push_back(r);
        endfunction

        task report_mismatch(input string what, input int got, input int want);
            $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, what, got, want);
            errors++;
        endtask

        task check_result(input logic [23:0] tdata);
            t_render_result got;
            t_render_result want;
            got = tdata[19:0];
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result", int'(got), 0);
                return;
            end
            want = due_results.pop_front();
            if (got.rdata !== want.rdata) begin
                report_mismatch("read_data", int'(got.rdata), int'(want.rdata));
            end
            if (got.column !== want.column) begin
                report_mismatch("column_now", int'(got.column), int'(want.column));
            end
            if (got.page !== want.page) begin
                report_mismatch("page_now", int'(got.page), int'(want.page));
            end
            if (got.dropped !== want.dropped) begin
                report_mismatch("char_dropped", int'(got.dropped), int'(want.dropped));
            end
        endtask
    endclass

endpackage

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the glyph page renderer: a directed opening over the
// cursor, drawing, newline, clear and read corners, then random command
// streams, all checked against a mirror of the frame store, with idle bursts
// on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import tgpr_pkg::*;
    import frame_mirror_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int ITEM_TOTAL  = 1950;
    localparam int CALM_TAIL   = 300;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire  [OUT_TDATA_W-1:0] m_tdata;

    bit          idle_on    = 1'b1;
    int          quiet      = 0;
    int          stall_left = 0;
    frame_mirror mirror;

    text_glyph_page_renderer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial forever #6 i_clk = ~i_clk;

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [39:0] make_item(input logic [7:0] code, input logic [7:0] tcol,
                                              input logic [7:0] tpage, input logic [9:0] addr);
        return {6'b0, addr, tpage, tcol, code};
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [39:0] data);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!s_tready);
        mirror.note_command(cmd, data);
    endtask

    task automatic put_char(input logic [7:0] code);
        send_item(CMD_PUT_CHAR,
                  make_item(code, any_byte(), any_byte(), 10'($urandom_range(0, 1023))));
    endtask

    task automatic set_cursor(input logic [7:0] tcol, input logic [7:0] tpage);
        send_item(CMD_SET_CURSOR,
                  make_item(any_byte(), tcol, tpage, 10'($urandom_range(0, 1023))));
    endtask

    task automatic read_byte(input logic [9:0] addr);
        send_item(CMD_READ, make_item(any_byte(), any_byte(), any_byte(), addr));
    endtask

    task automatic clear_store();
        send_item(CMD_CLEAR,
                  make_item(any_byte(), any_byte(), any_byte(), 10'($urandom_range(0, 1023))));
    endtask

    // Drops valid and holds off until every queued result has come back.
    task automatic hold_until_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
    endtask

    // Result side: ready drops in random bursts while idling is enabled.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if (m_tvalid && m_tready) mirror.check_result(m_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("text_glyph_page_renderer verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int         pick;
        int         sub;
        logic [7:0] tcol;
        logic [7:0] tpage;
        mirror = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty store, glyph edges, unprintable codes,
        // full line, last page, ignored cursor targets and clear.
        read_byte(10'd0);
        read_byte(10'd1023);
        put_char(8'd65);
        put_char(8'd0);
        put_char(8'd255);
        put_char(8'd127);
        put_char(8'd128);
        put_char(8'd32);
        read_byte(10'd1);
        put_char(8'd10);
        set_cursor(8'd127, 8'd7);
        put_char(8'd48);
        set_cursor(8'd122, 8'd7);
        put_char(8'd48);
        put_char(8'd126);
        read_byte(10'd1022);
        read_byte(10'd1023);
        put_char(8'd10);
        set_cursor(8'd255, 8'd255);
        set_cursor(8'd5, 8'd200);
        set_cursor(8'd200, 8'd3);
        set_cursor(8'd128, 8'd8);
        clear_store();
        read_byte(10'd1);
        read_byte(10'd1020);

        for (int n = 0; n < ITEM_TOTAL - 25; n++) begin
            if (n == (ITEM_TOTAL - 25) / 2) hold_until_drained();
            if (n == ITEM_TOTAL - 25 - CALM_TAIL) idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick == 0) begin
                clear_store();
            end else if (pick < 59) begin
                sub = $urandom_range(0, 99);
                if (sub < 8) put_char(8'd10);
                else if (sub < 80) put_char(8'($urandom_range(32, 127)));
                else put_char(any_byte());
            end else if (pick < 73) begin
                sub   = $urandom_range(0, 9);
                tcol  = (sub < 3) ? 8'($urandom_range(110, 127)) :
                        (sub < 8) ? 8'($urandom_range(0, 127)) : any_byte();
                tpage = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7)) : any_byte();
                set_cursor(tcol, tpage);
            end else begin
                // Most reads land on the page being drawn so glyph bytes show up.
                if ($urandom_range(0, 9) < 6) begin
                    read_byte(10'(mirror.page * MIRROR_COLS + $urandom_range(0, 127)));
                end else begin
                    read_byte(10'($urandom_range(0, 1023)));
                end
            end
        end

        hold_until_drained();
        repeat (30) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("text_glyph_page_renderer verification clean");
        end else begin
            $display("text_glyph_page_renderer verification failed");
        end
        $finish;
    end

endmodule
